// ===== hdl/circular_linked_list_engine_defines.svh =====
// Assertion macros used by the list engine top level.
// Depends on nothing; included by the top level after its net type line.
`ifndef CIRCULAR_LINKED_LIST_ENGINE_DEFINES_SVH
`define CIRCULAR_LINKED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CLLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define CLLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/clle_pkg.sv =====
// Shared types, codes and defaults of the circular linked list engine.
// Depends on nothing; used by the channel interfaces and every module.
`default_nettype none

package clle_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int KEY_BITS_DEF  = 32;

    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LIST   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } st_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_key;     // capture the key of the accepted item
        logic rd_head;      // read the node the sentinel points to
        logic rd_follow;    // read the successor of the node just read
        logic ins_a;        // write key and links of the new node
        logic ins_b;        // hook the new node in after the sentinel
        logic unlink;       // unlink the node just read
        logic clear;        // empty the list
        logic push;         // load the output register
        st_t  push_status;
        logic push_key;     // carry the key just read, else zero
        logic push_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic cur_is_sent;
        logic nxt_is_sent;
        logic match;
        logic steps_end;
        logic steps_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/clle_channels.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on clle_pkg for the field widths.
`default_nettype none

interface clle_req_if;
    logic                               valid;
    logic                               ready;
    logic        [clle_pkg::OP_W-1:0]   op;
    logic signed [clle_pkg::KEY_W-1:0]  key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface clle_rsp_if;
    logic                               valid;
    logic                               ready;
    logic        [clle_pkg::ST_W-1:0]   status;
    logic signed [clle_pkg::KEY_W-1:0]  key_out;
    logic                               last;

    modport source (output valid, output status, output key_out, output last, input ready);
    modport sink   (input valid, input status, input key_out, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/circular_linked_list_engine.sv =====
// Top level of the circular linked list engine: controller plus datapath.
// Depends on clle_pkg, clle_channels, clle_ctrl, clle_dpath and the
// assertion macros in circular_linked_list_engine_defines.svh.
//
//  Channel | Direction | Payload                  | Transfer per item
//  --------+-----------+--------------------------+--------------------------
//  req     | in        | op, key                  | one
//  rsp     | out       | status, key_out, last    | one, or one per node on list
//
// An insert runs S_INS and S_INS_LINK, or S_INS alone on a full pool, before
// S_RESP loads its result into the output register; clear runs only S_RESP.
// A delete walks the list one node per cycle, set by the single read port of
// the node pool memories. A list likewise produces one result per cycle once
// its first node has been read; stalls on rsp hold the walk in place. A new
// request is taken once the previous one has loaded its final result into
// the output register. Reset is asynchronous and leaves the list empty.
`default_nettype none
`include "circular_linked_list_engine_defines.svh"

module circular_linked_list_engine #(
    parameter int MAX_NODES = clle_pkg::MAX_NODES_DEF,
    parameter int KEY_BITS  = clle_pkg::KEY_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    clle_req_if.sink   req,
    clle_rsp_if.source rsp
);

    clle_pkg::cmd_t cmd;
    clle_pkg::sts_t sts;
    logic           ctrl_ready;

    // The controller owns the request handshake and all sequencing.
    clle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.op),
        .in_ready (ctrl_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign req.ready = ctrl_ready;

    // The datapath holds the node pool, the sentinel link and the output
    // register that drives the response channel.
    clle_dpath #(
        .MAX_NODES (MAX_NODES),
        .KEY_BITS  (KEY_BITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_in (req.key),
        .cmd    (cmd),
        .sts    (sts),
        .rsp    (rsp)
    );

    // A result is only ever loaded into a free output register.
    `CLLE_ASSERT_IMPLY(a_push_free, clk, rst_n, cmd.push, sts.out_free, "push into busy output")
    // A new node is only written while a slot is free.
    `CLLE_ASSERT_IMPLY(a_ins_room, clk, rst_n, cmd.ins_a, !sts.full, "insert into full pool")
    // Only a matching real node is ever unlinked, never the sentinel.
    `CLLE_ASSERT_IMPLY(a_unlink_ok, clk, rst_n, cmd.unlink, sts.match && !sts.cur_is_sent, "bad unlink")
    // Every request occupies the engine for at least the following cycle.
    `CLLE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready, "overlap")

endmodule

`default_nettype wire

// ===== hdl/clle_dpath.sv =====
// Datapath of the list engine: node pool memories, sentinel link, walk
// registers and the output register. Depends on clle_pkg and clle_rsp_if.
`default_nettype none

module clle_dpath #(
    parameter int MAX_NODES = clle_pkg::MAX_NODES_DEF,
    parameter int KEY_BITS  = clle_pkg::KEY_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic signed [clle_pkg::KEY_W-1:0]  key_in,
    input  wire clle_pkg::cmd_t                     cmd,
    output clle_pkg::sts_t                          sts,
    clle_rsp_if.source                              rsp
);

    localparam int LINK_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam logic [LINK_W-1:0] SENT = LINK_W'(MAX_NODES);

    logic signed [KEY_BITS-1:0]  key_mem [MAX_NODES];
    logic        [LINK_W-1:0]    nxt_mem [MAX_NODES];
    logic        [LINK_W-1:0]    prv_mem [MAX_NODES];

    logic signed [KEY_BITS-1:0]  key_reg;
    logic        [LINK_W-1:0]    head_reg;
    logic        [MAX_NODES-1:0] used_reg;
    logic        [IDX_W-1:0]     slot_reg;
    logic        [LINK_W-1:0]    cur_reg;
    logic        [LINK_W-1:0]    steps_reg;
    logic signed [KEY_BITS-1:0]  key_rd_reg;
    logic        [LINK_W-1:0]    nxt_rd_reg;
    logic        [LINK_W-1:0]    prv_rd_reg;

    logic                        out_valid_reg;
    clle_pkg::st_t               out_status_reg;
    logic signed [clle_pkg::KEY_W-1:0] out_key_reg;
    logic                        out_last_reg;

    logic [MAX_NODES-1:0] free_oh;
    logic [IDX_W-1:0]     free_idx;
    logic [LINK_W-1:0]    rd_addr;
    logic                 rd_en;
    logic                 out_free;

    logic                 nxt_we;
    logic [IDX_W-1:0]     nxt_wa;
    logic [LINK_W-1:0]    nxt_wd;
    logic                 prv_we;
    logic [IDX_W-1:0]     prv_wa;
    logic [LINK_W-1:0]    prv_wd;

    // Lowest free slot: isolate the lowest clear bit, then encode it.
    always_comb
    begin
        free_oh  = ~used_reg & (used_reg + MAX_NODES'(1));
        free_idx = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (free_oh[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    assign rd_en   = cmd.rd_head | cmd.rd_follow;
    assign rd_addr = cmd.rd_head ? head_reg : nxt_rd_reg;
    assign out_free = !out_valid_reg || rsp.ready;

    // Write ports of the link memories; the commands never coincide.
    always_comb
    begin
        nxt_we = 1'b0;
        nxt_wa = free_idx;
        nxt_wd = head_reg;
        prv_we = 1'b0;
        prv_wa = free_idx;
        prv_wd = SENT;
        priority if (cmd.ins_a)
        begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
        end
        else if (cmd.ins_b)
        begin
            prv_we = (head_reg != SENT);
            prv_wa = head_reg[IDX_W-1:0];
            prv_wd = LINK_W'(slot_reg);
        end
        else if (cmd.unlink)
        begin
            nxt_we = (prv_rd_reg != SENT);
            nxt_wa = prv_rd_reg[IDX_W-1:0];
            nxt_wd = nxt_rd_reg;
            prv_we = (nxt_rd_reg != SENT);
            prv_wa = nxt_rd_reg[IDX_W-1:0];
            prv_wd = prv_rd_reg;
        end
    end

    // Node pool memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.ins_a)
        begin
            key_mem[free_idx] <= key_reg;
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr[IDX_W-1:0]];
            nxt_rd_reg <= nxt_mem[rd_addr[IDX_W-1:0]];
            prv_rd_reg <= prv_mem[rd_addr[IDX_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= KEY_BITS'(key_in);
        end
        if (cmd.ins_a)
        begin
            slot_reg <= free_idx;
        end
        if (rd_en)
        begin
            cur_reg <= rd_addr;
        end
        if (cmd.rd_head)
        begin
            steps_reg <= '0;
        end
        else if (cmd.rd_follow)
        begin
            steps_reg <= steps_reg + LINK_W'(1);
        end
        if (cmd.push)
        begin
            out_status_reg <= cmd.push_status;
            out_key_reg    <= cmd.push_key ? clle_pkg::KEY_W'(key_rd_reg) : '0;
            out_last_reg   <= cmd.push_last;
        end
    end

    // List shape and output handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= SENT;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                head_reg <= SENT;
                used_reg <= '0;
            end
            else if (cmd.ins_b)
            begin
                head_reg <= LINK_W'(slot_reg);
                used_reg <= used_reg | (MAX_NODES'(1) << slot_reg);
            end
            else if (cmd.unlink)
            begin
                if (prv_rd_reg == SENT)
                begin
                    head_reg <= nxt_rd_reg;
                end
                used_reg <= used_reg & ~(MAX_NODES'(1) << cur_reg[IDX_W-1:0]);
            end

            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.full        = &used_reg;
    assign sts.cur_is_sent = (cur_reg == SENT);
    assign sts.nxt_is_sent = (nxt_rd_reg == SENT);
    assign sts.match       = (key_rd_reg == key_reg);
    assign sts.steps_end   = (steps_reg == LINK_W'(MAX_NODES));
    assign sts.steps_last  = (steps_reg == LINK_W'(MAX_NODES - 1));
    assign sts.out_free    = out_free;

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.key_out = out_key_reg;
    assign rsp.last    = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/clle_ctrl.sv =====
// Controller of the list engine: sequences insert, delete, list and clear
// through commands to the datapath. Depends on clle_pkg.
`default_nettype none

module clle_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [clle_pkg::OP_W-1:0]   in_op,
    output logic                             in_ready,
    input  wire clle_pkg::sts_t              sts,
    output clle_pkg::cmd_t                   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LINK,
        S_DEL,
        S_LIST,
        S_RESP
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    clle_pkg::st_t resp_reg;
    clle_pkg::st_t resp_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        resp_next  = resp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_key = 1'b1;
                    unique case (clle_pkg::op_t'(in_op))
                        clle_pkg::OP_INSERT:
                        begin
                            state_next = S_INS;
                        end
                        clle_pkg::OP_DELETE:
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = S_DEL;
                        end
                        clle_pkg::OP_LIST:
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = S_LIST;
                        end
                        clle_pkg::OP_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            resp_next  = clle_pkg::ST_OK;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                if (sts.full)
                begin
                    resp_next  = clle_pkg::ST_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.ins_a  = 1'b1;
                    state_next = S_INS_LINK;
                end
            end
            S_INS_LINK:
            begin
                cmd.ins_b  = 1'b1;
                resp_next  = clle_pkg::ST_OK;
                state_next = S_RESP;
            end
            S_DEL:
            begin
                priority if (sts.cur_is_sent || sts.steps_end)
                begin
                    resp_next  = clle_pkg::ST_NOT_FOUND;
                    state_next = S_RESP;
                end
                else if (sts.match)
                begin
                    cmd.unlink = 1'b1;
                    resp_next  = clle_pkg::ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_follow = 1'b1;
                end
            end
            S_LIST:
            begin
                priority if (sts.cur_is_sent)
                begin
                    resp_next  = clle_pkg::ST_EMPTY;
                    state_next = S_RESP;
                end
                else if (sts.out_free)
                begin
                    cmd.push        = 1'b1;
                    cmd.push_status = clle_pkg::ST_OK;
                    cmd.push_key    = 1'b1;
                    cmd.push_last   = sts.nxt_is_sent || sts.steps_last;
                    if (cmd.push_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_follow = 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.push        = 1'b1;
                    cmd.push_status = resp_reg;
                    cmd.push_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resp_reg  <= clle_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

endmodule

`default_nettype wire
